/* hdl/pattern_occurrence_range_query_unit_defines.svh */
// Assertion macros used by the file that carries the concurrent checks.
`ifndef PATTERN_OCCURRENCE_RANGE_QUERY_UNIT_DEFINES_SVH
`define PATTERN_OCCURRENCE_RANGE_QUERY_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PORQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PORQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/porq_pkg.sv */
package porq_pkg;

   localparam int TEXT_MAX    = 4096;
   localparam int PATTERN_MAX = 32;
   localparam int POS_W       = $clog2(TEXT_MAX);
   localparam int CNT_W       = POS_W + 1;
   localparam int RANGE_W     = 13;
   localparam int CMP_W       = ((RANGE_W > CNT_W) ? RANGE_W : CNT_W) + 1;
   localparam int LEN_W       = 6;
   localparam int PI_W        = 5;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PAT_WORDS   = 4;
   localparam int CMD_DEPTH   = 4;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PLEN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT3 = 3'd4;

   typedef struct packed {
      logic [1:0]         op;
      logic [POS_W-1:0]   start;
      logic [RANGE_W-1:0] thr;
      logic [RANGE_W-1:0] last;
      logic [LEN_W-1:0]   len;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] text_len;
   } front_status_type;

   typedef struct packed {
      logic [CNT_W-1:0] occ_count;
   } back_status_type;

   // Pattern length in use: zero acts as one, anything above the maximum as the maximum.
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
      logic [LEN_W-1:0] r;
      r = n;
      if (n == '0) r = LEN_W'(1);
      if (n > LEN_W'(PATTERN_MAX)) r = LEN_W'(PATTERN_MAX);
      return r;
   endfunction

endpackage

/* hdl/porq_ram.sv */
module porq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* hdl/porq_cmd_queue.sv */
module porq_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  porq_pkg::cmd_type cmd_in,
   output logic             full,
   input  logic             pop,
   output porq_pkg::cmd_type cmd_out,
   output logic             empty
);
   import porq_pkg::*;

   localparam int QA_W = $clog2(CMD_DEPTH);

   cmd_type         slot_ff [CMD_DEPTH];
   logic [QA_W-1:0] wp_ff, rp_ff;
   logic [QA_W:0]   cnt_ff;
   logic            do_push, do_pop;

   assign full    = (cnt_ff == (QA_W + 1)'(CMD_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign cmd_out = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= cmd_in;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= wp_ff + QA_W'(1);
         if (do_pop)  rp_ff <= rp_ff + QA_W'(1);
         if (do_push && !do_pop) cnt_ff <= cnt_ff + (QA_W + 1)'(1);
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - (QA_W + 1)'(1);
      end
   end
endmodule

/* hdl/porq_front.sv */
module porq_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [1:0]                        req_operation,
   input  logic [7:0]                        req_text_byte,
   input  logic [porq_pkg::RANGE_W-1:0]      req_range_first,
   input  logic [porq_pkg::RANGE_W-1:0]      req_range_last,
   input  logic                              csr_write,
   input  logic [porq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [porq_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              cmd_push,
   output porq_pkg::cmd_type                 cmd,
   output porq_pkg::front_status_type        status
);
   import porq_pkg::*;

   logic [LEN_W-1:0]                      plen_ff;
   logic [PAT_WORDS-1:0][CSR_DATA_W-1:0]  pat_ff;
   logic [PATTERN_MAX-1:0][7:0]           recent_ff;
   logic [CNT_W-1:0]                      tlen_ff;

   logic [PATTERN_MAX-1:0][7:0] pat_b;
   logic [PATTERN_MAX-1:0][7:0] win;
   logic [PATTERN_MAX-1:0]      eq;
   logic [LEN_W-1:0]            len;
   logic [LEN_W-1:0]            idx;
   logic [CNT_W-1:0]            new_len;
   logic                        text_full, match;

   assign pat_b     = pat_ff;
   assign win       = {recent_ff[PATTERN_MAX-2:0], req_text_byte};
   assign len       = eff_len(plen_ff);
   assign new_len   = tlen_ff + CNT_W'(1);
   assign text_full = (tlen_ff >= CNT_W'(TEXT_MAX));

   // Window byte j (newest first) lines up with pattern byte len-1-j.
   always_comb begin
      idx = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         idx   = len - LEN_W'(j) - LEN_W'(1);
         eq[j] = (LEN_W'(j) >= len) || (win[j] == pat_b[idx[PI_W-1:0]]);
      end
   end

   assign match = (&eq) && (new_len >= CNT_W'(len));

   always_comb begin
      cmd.op    = req_operation;
      cmd.start = POS_W'(new_len - CNT_W'(len));
      cmd.thr   = (req_range_first == '0) ? '0 : req_range_first - RANGE_W'(1);
      cmd.last  = req_range_last;
      cmd.len   = len;
      case (req_operation)
         OP_APPEND: cmd_push = accept && !text_full && match;
         OP_QUERY,
         OP_CLEAR:  cmd_push = accept;
         default:   cmd_push = 1'b0;
      endcase
   end

   assign status.text_len = tlen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff   <= LEN_W'(1);
         pat_ff    <= '0;
         recent_ff <= '0;
         tlen_ff   <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_PLEN: plen_ff   <= csr_wdata[LEN_W-1:0];
               CSR_PAT0: pat_ff[0] <= csr_wdata;
               CSR_PAT1: pat_ff[1] <= csr_wdata;
               CSR_PAT2: pat_ff[2] <= csr_wdata;
               CSR_PAT3: pat_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
         if (accept && req_operation == OP_APPEND && !text_full) begin
            recent_ff <= win;
            tlen_ff   <= new_len;
         end else if (accept && req_operation == OP_CLEAR) begin
            recent_ff <= '0;
            tlen_ff   <= '0;
         end
      end
   end
endmodule

/* hdl/porq_back.sv */
module porq_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_empty,
   input  porq_pkg::cmd_type         cmd,
   output logic                      cmd_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic                      rsp_contains_pattern,
   output porq_pkg::back_status_type status
);
   import porq_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_STEP  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_FINAL = 3'd3;

   logic [2:0]         state_ff;
   logic [CNT_W-1:0]   lo_ff, hi_ff, mid_ff, count_ff;
   logic [RANGE_W-1:0] thr_ff, last_ff;
   logic [LEN_W-1:0]   len_ff;
   logic               out_valid_ff, out_bit_ff;

   logic [CNT_W:0]     sum;
   logic [CNT_W-1:0]   mid;
   logic [POS_W-1:0]   raddr, rdata;
   logic               we;

   assign sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid   = sum[CNT_W:1];
   assign raddr = (lo_ff < hi_ff) ? mid[POS_W-1:0] : lo_ff[POS_W-1:0];

   assign cmd_pop = (state_ff == ST_IDLE) && !cmd_empty
                    && (cmd.op != OP_QUERY || !out_valid_ff);
   assign we      = cmd_pop && cmd.op == OP_APPEND && count_ff < CNT_W'(TEXT_MAX);

   porq_ram #(.WIDTH(POS_W), .DEPTH(TEXT_MAX)) u_starts (
      .clock (clock),
      .we    (we),
      .waddr (count_ff[POS_W-1:0]),
      .wdata (cmd.start),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rsp_empty            = !out_valid_ff;
   assign rsp_contains_pattern = out_bit_ff;
   assign status.occ_count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && out_valid_ff) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_pop) begin
                  case (cmd.op)
                     OP_APPEND: if (we) count_ff <= count_ff + CNT_W'(1);
                     OP_CLEAR:  count_ff <= '0;
                     OP_QUERY: begin
                        lo_ff    <= '0;
                        hi_ff    <= count_ff;
                        thr_ff   <= cmd.thr;
                        last_ff  <= cmd.last;
                        len_ff   <= cmd.len;
                        state_ff <= ST_STEP;
                     end
                     default: ;
                  endcase
               end
            end
            ST_STEP: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid;
                  state_ff <= ST_CHECK;
               end else if (lo_ff >= count_ff) begin
                  out_bit_ff   <= 1'b0;
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  state_ff <= ST_FINAL;
               end
            end
            ST_CHECK: begin
               if (CMP_W'(rdata) < CMP_W'(thr_ff)) lo_ff <= mid_ff + CNT_W'(1);
               else hi_ff <= mid_ff;
               state_ff <= ST_STEP;
            end
            ST_FINAL: begin
               out_bit_ff   <= (CMP_W'(rdata) + CMP_W'(len_ff)) <= CMP_W'(last_ff);
               out_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

/* hdl/pattern_occurrence_range_query_unit.sv */
// Pattern occurrence range query unit. Words pushed on the req_ side either append a text byte,
// ask whether a 1-based position range holds a whole occurrence of the configured pattern, or
// clear the text. A front stage takes one word per cycle while the command queue has room,
// keeps the newest 32 text bytes and compares them with the pattern on every append; matches,
// queries and clears travel through a four-entry command queue to a back stage that keeps the
// sorted start list in a 4096-entry memory. A query binary-searches the start list; each search
// step passes through a step state that issues the memory read and a check state that compares
// the registered data; when a start is found, a final state checks it against the range end.
// Only queries produce a response word, which waits in an output register while the back stage
// keeps draining appends and clears. The pattern registers take effect on the next word and
// should be written only while the unit is idle. No memory clearing is needed after reset;
// only entries below the occurrence count are ever read.
module pattern_occurrence_range_query_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [1:0]                      req_operation,
   input  logic [7:0]                      req_text_byte,
   input  logic [porq_pkg::RANGE_W-1:0]    req_range_first,
   input  logic [porq_pkg::RANGE_W-1:0]    req_range_last,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_contains_pattern,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [porq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [porq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import porq_pkg::*;
`include "pattern_occurrence_range_query_unit_defines.svh"

   cmd_type          fe_cmd, be_cmd;
   logic             fe_push, q_full, q_empty, be_pop, accept;
   front_status_type fe_status;
   back_status_type  be_status;

   // The configuration port never stalls.
   assign csr_ready = 1'b1;
   // A word is taken whenever the command queue has room, whatever it turns into.
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   porq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_operation   (req_operation),
      .req_text_byte   (req_text_byte),
      .req_range_first (req_range_first),
      .req_range_last  (req_range_last),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd_push        (fe_push),
      .cmd             (fe_cmd),
      .status          (fe_status)
   );

   porq_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fe_push),
      .cmd_in  (fe_cmd),
      .full    (q_full),
      .pop     (be_pop),
      .cmd_out (be_cmd),
      .empty   (q_empty)
   );

   porq_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cmd_empty            (q_empty),
      .cmd                  (be_cmd),
      .cmd_pop              (be_pop),
      .rsp_pop              (rsp_pop),
      .rsp_empty            (rsp_empty),
      .rsp_contains_pattern (rsp_contains_pattern),
      .status               (be_status)
   );

   // A reset leaves no response pending.
   `PORQ_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty, "response pending after reset")
   // The text length never runs past the capacity.
   `PORQ_ASSERT_SAME(a_text_bound, clock, reset, 1'b1, fe_status.text_len <= CNT_W'(TEXT_MAX), "text length overflow")
   // The occurrence list never runs past the capacity.
   `PORQ_ASSERT_SAME(a_occ_bound, clock, reset, 1'b1, be_status.occ_count <= CNT_W'(TEXT_MAX), "occurrence count overflow")
endmodule
